// ----- rtl/ted_pkg.sv -----
package ted_pkg;

  localparam int unsigned DATA_W  = 8;
  localparam int unsigned SCORE_W = 21;
  localparam int unsigned ENC_W   = 4;
  localparam int unsigned OUT_W   = 48;

  localparam longint unsigned MAX_SCORE_DEF = 64'd1048576;
  localparam longint unsigned SCORE_FIELD_MAX = 64'd2097151;

  typedef enum logic [ENC_W-1:0] {
    ENC_UNKNOWN  = 4'd0,
    ENC_ASCII    = 4'd1,
    ENC_UTF8_BOM = 4'd2,
    ENC_UTF32LE  = 4'd3,
    ENC_UTF32BE  = 4'd4,
    ENC_UTF16LE  = 4'd5,
    ENC_UTF16BE  = 4'd6,
    ENC_UTF8     = 4'd7,
    ENC_SJIS     = 4'd8
  } enc_t;

  typedef logic [SCORE_W-1:0] score_t;
  typedef logic [DATA_W-1:0]  byte_t;

  // number of continuation bytes a strict utf-8 lead byte calls for
  function automatic logic [1:0] utf8_extra(input byte_t b);
    logic [1:0] x;
    x = 2'd0;
    if (b >= 8'hC2 && b <= 8'hDF) x = 2'd1;
    else if (b >= 8'hE0 && b <= 8'hEF) x = 2'd2;
    else if (b >= 8'hF0 && b <= 8'hF4) x = 2'd3;
    return x;
  endfunction

  function automatic score_t score_add(input score_t s, input logic [2:0] n,
                                       input score_t cap);
    logic [SCORE_W:0] v;
    v = {1'b0, s} + {{(SCORE_W-2){1'b0}}, n};
    if (v > {1'b0, cap}) v = {1'b0, cap};
    return v[SCORE_W-1:0];
  endfunction

endpackage

// ----- rtl/text_encoding_detector_core.sv -----
// Text encoding detector. Bytes of one buffer enter on the in_ stream, one per transaction,
// with in_tlast on the last byte; on that byte one verdict leaves on the out_ stream and all
// detection state returns to its reset values for the next buffer. The verdict is a BOM
// match on the first bytes (utf-8, utf-32le, utf-32be, utf-16le, utf-16be in that order),
// else ascii, else strict utf-8 against shift-jis (cp932) by score; both saturating scores
// are always reported. One byte per cycle is accepted: each byte passes an input register,
// then compare and counter-update logic, and (for the last byte) the result register that
// drives out_tdata. Only the last byte of a buffer waits on a full result register.
module text_encoding_detector_core #(
  parameter longint unsigned MAX_SCORE = ted_pkg::MAX_SCORE_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [ted_pkg::DATA_W-1:0] in_tdata,   // [7:0] data_byte
  input  logic                       in_tlast,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [ted_pkg::OUT_W-1:0]  out_tdata   // [3:0] encoding, [24:4] utf8_points,
                                                 // [45:25] sjis_points, [47:46] zero
);

  localparam longint unsigned CAP_L =
    (MAX_SCORE > ted_pkg::SCORE_FIELD_MAX) ? ted_pkg::SCORE_FIELD_MAX : MAX_SCORE;
  localparam ted_pkg::score_t SCORE_CAP = CAP_L[ted_pkg::SCORE_W-1:0];

  // input register
  logic           stg_vld_r;
  ted_pkg::byte_t stg_byte_r;
  logic           stg_last_r;

  // detection state
  ted_pkg::byte_t  head_r [4];
  logic [2:0]      seen_r;
  logic            ascii_r;
  logic [1:0]      u_rem_r;
  ted_pkg::byte_t  u_lead_r;
  logic            u_fail_r;
  ted_pkg::score_t u_score_r;
  logic            s_pend_r;
  logic            s_fail_r;
  ted_pkg::score_t s_score_r;

  // result register
  logic            out_vld_r;
  ted_pkg::enc_t   out_enc_r;
  ted_pkg::score_t out_u_r;
  ted_pkg::score_t out_s_r;

  ted_pkg::byte_t  head_nxt [4];
  logic [2:0]      seen_nxt;
  logic            ascii_nxt;
  logic [1:0]      u_rem_nxt;
  ted_pkg::byte_t  u_lead_nxt;
  logic            u_fail_nxt;
  ted_pkg::score_t u_score_nxt;
  logic            s_pend_nxt;
  logic            s_fail_nxt;
  ted_pkg::score_t s_score_nxt;
  ted_pkg::enc_t   enc_nxt;

  logic out_free;
  logic process;
  logic stg_take;

  assign out_free  = !out_vld_r || out_tready;
  assign process   = stg_vld_r && (!stg_last_r || out_free);
  assign in_tready = !stg_vld_r || process;
  assign stg_take  = in_tvalid && in_tready;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, out_s_r, out_u_r, out_enc_r};

  always_comb begin
    ted_pkg::byte_t b;
    logic           last;
    logic [1:0]     x;
    ted_pkg::byte_t lo;
    ted_pkg::byte_t hi;
    b    = stg_byte_r;
    last = stg_last_r;
    x    = 2'd0;
    lo   = 8'h80;
    hi   = 8'hBF;

    for (int i = 0; i < 4; i++) head_nxt[i] = head_r[i];
    seen_nxt = seen_r;
    if (seen_r < 3'd4) begin
      head_nxt[seen_r[1:0]] = b;
      seen_nxt = seen_r + 3'd1;
    end
    ascii_nxt = ascii_r && (b <= 8'h7F);

    // strict utf-8
    u_rem_nxt   = u_rem_r;
    u_lead_nxt  = u_lead_r;
    u_fail_nxt  = u_fail_r;
    u_score_nxt = u_score_r;
    if (!u_fail_r) begin
      if (u_rem_r == 2'd0) begin
        if (b > 8'h7F) begin
          x = ted_pkg::utf8_extra(b);
          if (x == 2'd0 || last) begin
            u_fail_nxt = 1'b1;
          end else begin
            u_lead_nxt = b;
            u_rem_nxt  = x;
          end
        end
      end else begin
        x = ted_pkg::utf8_extra(u_lead_r);
        if (u_rem_r == x) begin
          if (u_lead_r == 8'hE0) lo = 8'hA0;
          else if (u_lead_r == 8'hED) hi = 8'h9F;
          else if (u_lead_r == 8'hF0) lo = 8'h90;
          else if (u_lead_r == 8'hF4) hi = 8'h8F;
        end
        if (b < lo || b > hi) begin
          u_fail_nxt = 1'b1;
        end else begin
          u_rem_nxt = u_rem_r - 2'd1;
          if (u_rem_r == 2'd1) begin
            u_score_nxt = ted_pkg::score_add(u_score_r, {1'b0, x} + 3'd1, SCORE_CAP);
          end else if (last) begin
            u_fail_nxt = 1'b1;
          end
        end
      end
    end

    // shift-jis with cp932 single bytes
    s_pend_nxt  = s_pend_r;
    s_fail_nxt  = s_fail_r;
    s_score_nxt = s_score_r;
    if (!s_fail_r) begin
      if (s_pend_r) begin
        s_pend_nxt = 1'b0;
        if ((b >= 8'h40 && b <= 8'h7E) || (b >= 8'h80 && b <= 8'hFC)) begin
          s_score_nxt = ted_pkg::score_add(s_score_r, 3'd2, SCORE_CAP);
        end else begin
          s_fail_nxt = 1'b1;
        end
      end else if (b <= 8'h80 || b == 8'hA0 || b >= 8'hFD) begin
        s_pend_nxt = 1'b0;
      end else if (b >= 8'hA1 && b <= 8'hDF) begin
        s_score_nxt = ted_pkg::score_add(s_score_r, 3'd1, SCORE_CAP);
      end else if (last) begin
        s_fail_nxt = 1'b1;
      end else begin
        s_pend_nxt = 1'b1;
      end
    end

    // verdict
    if (seen_nxt >= 3'd3 && head_nxt[0] == 8'hEF && head_nxt[1] == 8'hBB
        && head_nxt[2] == 8'hBF) begin
      enc_nxt = ted_pkg::ENC_UTF8_BOM;
    end else if (seen_nxt == 3'd4 && head_nxt[0] == 8'hFF && head_nxt[1] == 8'hFE
                 && head_nxt[2] == 8'h00 && head_nxt[3] == 8'h00) begin
      enc_nxt = ted_pkg::ENC_UTF32LE;
    end else if (seen_nxt == 3'd4 && head_nxt[0] == 8'h00 && head_nxt[1] == 8'h00
                 && head_nxt[2] == 8'hFE && head_nxt[3] == 8'hFF) begin
      enc_nxt = ted_pkg::ENC_UTF32BE;
    end else if (seen_nxt >= 3'd2 && head_nxt[0] == 8'hFF && head_nxt[1] == 8'hFE) begin
      enc_nxt = ted_pkg::ENC_UTF16LE;
    end else if (seen_nxt >= 3'd2 && head_nxt[0] == 8'hFE && head_nxt[1] == 8'hFF) begin
      enc_nxt = ted_pkg::ENC_UTF16BE;
    end else if (ascii_nxt) begin
      enc_nxt = ted_pkg::ENC_ASCII;
    end else if (!s_fail_nxt && (u_fail_nxt || s_score_nxt > u_score_nxt)) begin
      enc_nxt = ted_pkg::ENC_SJIS;
    end else if (!u_fail_nxt) begin
      enc_nxt = ted_pkg::ENC_UTF8;
    end else begin
      enc_nxt = ted_pkg::ENC_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (stg_take) begin
      stg_vld_r <= 1'b1;
    end else if (process) begin
      stg_vld_r <= 1'b0;
    end
    if (stg_take) begin
      stg_byte_r <= in_tdata;
      stg_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (process && stg_last_r)) begin
      for (int i = 0; i < 4; i++) head_r[i] <= '0;
      seen_r    <= '0;
      ascii_r   <= 1'b1;
      u_rem_r   <= '0;
      u_lead_r  <= '0;
      u_fail_r  <= 1'b0;
      u_score_r <= '0;
      s_pend_r  <= 1'b0;
      s_fail_r  <= 1'b0;
      s_score_r <= '0;
    end else if (process) begin
      for (int i = 0; i < 4; i++) head_r[i] <= head_nxt[i];
      seen_r    <= seen_nxt;
      ascii_r   <= ascii_nxt;
      u_rem_r   <= u_rem_nxt;
      u_lead_r  <= u_lead_nxt;
      u_fail_r  <= u_fail_nxt;
      u_score_r <= u_score_nxt;
      s_pend_r  <= s_pend_nxt;
      s_fail_r  <= s_fail_nxt;
      s_score_r <= s_score_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (process && stg_last_r) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
    if (process && stg_last_r) begin
      out_enc_r <= enc_nxt;
      out_u_r   <= u_score_nxt;
      out_s_r   <= s_score_nxt;
    end
  end

endmodule

// ----- test/text_encoding_detector_core_test.sv -----
`timescale 1ns / 100ps

module text_encoding_detector_core_test;

  localparam longint unsigned PTS_CAP =
    (ted_pkg::MAX_SCORE_DEF < ted_pkg::SCORE_FIELD_MAX) ?
    ted_pkg::MAX_SCORE_DEF : ted_pkg::SCORE_FIELD_MAX;
  localparam int RANDOM_BYTES = 1450;
  localparam int HOLD_CYCLES  = 400;

  typedef struct {
    ted_pkg::enc_t   enc;
    ted_pkg::score_t u8;
    ted_pkg::score_t sj;
  } verdict_t;

  typedef struct {
    ted_pkg::byte_t  b;
    bit              last;
    bit              typed;
    ted_pkg::enc_t   enc;
    ted_pkg::score_t u8;
    ted_pkg::score_t sj;
  } row_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TRICKLE} rx_mode_t;

  logic                       clk;
  logic                       rst_n = 1'b0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [ted_pkg::DATA_W-1:0] in_tdata = '0;
  logic                       in_tlast = 1'b0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [ted_pkg::OUT_W-1:0]  out_tdata;

  logic in_took = 1'b0;
  bit   hold_req = 1'b0;
  bit   steady = 1'b0;
  int   burst_left = 0;
  int   bytes_sent = 0;
  int   buffers_sent = 0;
  int   verdicts = 0;
  int   mismatches = 0;
  int   enc_hits [9];

  // detector state mirror
  ted_pkg::byte_t  head_q [4];
  logic [2:0]      head_cnt;
  bit              pure_ascii;
  logic [1:0]      u8_left;
  ted_pkg::byte_t  u8_lead;
  bit              u8_bad;
  ted_pkg::score_t u8_pts;
  bit              sj_pend;
  bit              sj_bad;
  ted_pkg::score_t sj_pts;

  verdict_t       exp_q [$];
  bit             pin_next = 1'b0;
  verdict_t       pin_v;
  ted_pkg::byte_t text_q [$];

  row_t plan [0:25] = '{
    '{8'h00, 1'b1, 1'b1, ted_pkg::ENC_ASCII,    0, 0},
    '{8'h7F, 1'b1, 1'b1, ted_pkg::ENC_ASCII,    0, 0},
    '{8'hEF, 1'b0, 1'b0, ted_pkg::ENC_UNKNOWN,  0, 0},
    '{8'hBB, 1'b0, 1'b0, ted_pkg::ENC_UNKNOWN,  0, 0},
    '{8'hBF, 1'b1, 1'b1, ted_pkg::ENC_UTF8_BOM, 3, 3},
    '{8'hFF, 1'b0, 1'b0, ted_pkg::ENC_UNKNOWN,  0, 0},
    '{8'hFE, 1'b0, 1'b0, ted_pkg::ENC_UNKNOWN,  0, 0},
    '{8'h00, 1'b0, 1'b0, ted_pkg::ENC_UNKNOWN,  0, 0},
    '{8'h00, 1'b1, 1'b1, ted_pkg::ENC_UTF32LE,  0, 0},
    '{8'h00, 1'b0, 1'b0, ted_pkg::ENC_UNKNOWN,  0, 0},
    '{8'h00, 1'b0, 1'b0, ted_pkg::ENC_UNKNOWN,  0, 0},
    '{8'hFE, 1'b0, 1'b0, ted_pkg::ENC_UNKNOWN,  0, 0},
    '{8'hFF, 1'b1, 1'b1, ted_pkg::ENC_UTF32BE,  0, 0},
    '{8'hFF, 1'b0, 1'b0, ted_pkg::ENC_UNKNOWN,  0, 0},
    '{8'hFE, 1'b0, 1'b0, ted_pkg::ENC_UNKNOWN,  0, 0},
    '{8'h41, 1'b1, 1'b1, ted_pkg::ENC_UTF16LE,  0, 0},
    '{8'hFE, 1'b0, 1'b0, ted_pkg::ENC_UNKNOWN,  0, 0},
    '{8'hFF, 1'b1, 1'b1, ted_pkg::ENC_UTF16BE,  0, 0},
    '{8'hFF, 1'b1, 1'b1, ted_pkg::ENC_SJIS,     0, 0},
    '{8'hC3, 1'b0, 1'b0, ted_pkg::ENC_UNKNOWN,  0, 0},
    '{8'hA9, 1'b1, 1'b0, ted_pkg::ENC_UNKNOWN,  0, 0},
    '{8'h82, 1'b0, 1'b0, ted_pkg::ENC_UNKNOWN,  0, 0},
    '{8'hA0, 1'b1, 1'b0, ted_pkg::ENC_UNKNOWN,  0, 0},
    '{8'hE3, 1'b1, 1'b1, ted_pkg::ENC_UNKNOWN,  0, 0},
    '{8'hED, 1'b0, 1'b0, ted_pkg::ENC_UNKNOWN,  0, 0},
    '{8'hA0, 1'b1, 1'b0, ted_pkg::ENC_UNKNOWN,  0, 0}
  };

  text_encoding_detector_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic ted_pkg::score_t sat_add(input ted_pkg::score_t s, input int unsigned n);
    longint unsigned v;
    v = s;
    v = v + n;
    if (v > PTS_CAP) v = PTS_CAP;
    return ted_pkg::score_t'(v);
  endfunction

  function automatic logic [1:0] u8_tail(input ted_pkg::byte_t b);
    if (b >= 8'hC2 && b <= 8'hDF) return 2'd1;
    if (b >= 8'hE0 && b <= 8'hEF) return 2'd2;
    if (b >= 8'hF0 && b <= 8'hF4) return 2'd3;
    return 2'd0;
  endfunction

  function automatic ted_pkg::byte_t rnd_byte(input int lo, input int hi);
    return ted_pkg::byte_t'($urandom_range(hi, lo));
  endfunction

  task automatic clear_state();
    foreach (head_q[i]) head_q[i] = '0;
    head_cnt   = '0;
    pure_ascii = 1'b1;
    u8_left    = '0;
    u8_lead    = '0;
    u8_bad     = 1'b0;
    u8_pts     = '0;
    sj_pend    = 1'b0;
    sj_bad     = 1'b0;
    sj_pts     = '0;
  endtask

  task automatic predict_byte(input ted_pkg::byte_t b, input bit last);
    verdict_t       v;
    logic [1:0]     tail;
    ted_pkg::byte_t lo;
    ted_pkg::byte_t hi;
    logic [31:0]    head4;
    if (head_cnt < 3'd4) begin
      head_q[head_cnt[1:0]] = b;
      head_cnt = head_cnt + 3'd1;
    end
    if (b > 8'h7F) pure_ascii = 1'b0;

    if (!u8_bad) begin
      if (u8_left == 2'd0) begin
        if (b > 8'h7F) begin
          tail = u8_tail(b);
          if (tail == 2'd0 || last) begin
            u8_bad = 1'b1;
          end else begin
            u8_lead = b;
            u8_left = tail;
          end
        end
      end else begin
        tail = u8_tail(u8_lead);
        lo = 8'h80;
        hi = 8'hBF;
        if (u8_left == tail) begin
          case (u8_lead)
            8'hE0: lo = 8'hA0;
            8'hED: hi = 8'h9F;
            8'hF0: lo = 8'h90;
            8'hF4: hi = 8'h8F;
            default: ;
          endcase
        end
        if (b < lo || b > hi) begin
          u8_bad = 1'b1;
        end else begin
          u8_left = u8_left - 2'd1;
          if (u8_left == 2'd0) u8_pts = sat_add(u8_pts, tail + 1);
          else if (last) u8_bad = 1'b1;
        end
      end
    end

    if (!sj_bad) begin
      if (sj_pend) begin
        sj_pend = 1'b0;
        if ((b >= 8'h40 && b <= 8'h7E) || (b >= 8'h80 && b <= 8'hFC))
          sj_pts = sat_add(sj_pts, 2);
        else
          sj_bad = 1'b1;
      end else if (b >= 8'hA1 && b <= 8'hDF) begin
        sj_pts = sat_add(sj_pts, 1);
      end else if ((b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hFC)) begin
        if (last) sj_bad = 1'b1;
        else sj_pend = 1'b1;
      end
    end

    if (last) begin
      head4 = {head_q[0], head_q[1], head_q[2], head_q[3]};
      if (head_cnt >= 3'd3 && head4[31:8] == 24'hEFBBBF) v.enc = ted_pkg::ENC_UTF8_BOM;
      else if (head_cnt == 3'd4 && head4 == 32'hFFFE0000) v.enc = ted_pkg::ENC_UTF32LE;
      else if (head_cnt == 3'd4 && head4 == 32'h0000FEFF) v.enc = ted_pkg::ENC_UTF32BE;
      else if (head_cnt >= 3'd2 && head4[31:16] == 16'hFFFE) v.enc = ted_pkg::ENC_UTF16LE;
      else if (head_cnt >= 3'd2 && head4[31:16] == 16'hFEFF) v.enc = ted_pkg::ENC_UTF16BE;
      else if (pure_ascii) v.enc = ted_pkg::ENC_ASCII;
      else begin
        v.enc = ted_pkg::ENC_UNKNOWN;
        if (!u8_bad) v.enc = ted_pkg::ENC_UTF8;
        if (!sj_bad && (u8_bad || sj_pts > u8_pts)) v.enc = ted_pkg::ENC_SJIS;
      end
      v.u8 = u8_pts;
      v.sj = sj_pts;
      if (pin_next) begin
        v = pin_v;
        pin_next = 1'b0;
      end
      exp_q.push_back(v);
      clear_state();
    end
  endtask

  task automatic push_byte(input ted_pkg::byte_t b, input bit last);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_took);
    predict_byte(b, last);
    bytes_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(60, 150);
        gap = 0;
      end else begin
        burst_left = $urandom_range(1, 40);
        gap = steady ? 0 : $urandom_range(0, 6);
      end
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_text();
    foreach (text_q[i]) push_byte(text_q[i], i == text_q.size() - 1);
    buffers_sent++;
  endtask

  task automatic add_utf8_char();
    int             n;
    ted_pkg::byte_t lead;
    ted_pkg::byte_t lo;
    ted_pkg::byte_t hi;
    n = $urandom_range(0, 3);
    if (n == 0) begin
      text_q.push_back(rnd_byte(0, 8'h7F));
      return;
    end
    case (n)
      1: lead = rnd_byte(8'hC2, 8'hDF);
      2: lead = rnd_byte(8'hE0, 8'hEF);
      default: lead = rnd_byte(8'hF0, 8'hF4);
    endcase
    // favor the leads with a narrowed second byte
    if (n == 2 && $urandom_range(0, 2) == 0) lead = $urandom_range(0, 1) ? 8'hE0 : 8'hED;
    if (n == 3 && $urandom_range(0, 1) == 0) lead = $urandom_range(0, 1) ? 8'hF0 : 8'hF4;
    lo = 8'h80;
    hi = 8'hBF;
    case (lead)
      8'hE0: lo = 8'hA0;
      8'hED: hi = 8'h9F;
      8'hF0: lo = 8'h90;
      8'hF4: hi = 8'h8F;
      default: ;
    endcase
    text_q.push_back(lead);
    text_q.push_back(rnd_byte(lo, hi));
    repeat (n - 1) text_q.push_back(rnd_byte(8'h80, 8'hBF));
  endtask

  task automatic add_sjis_char();
    int n;
    n = $urandom_range(0, 3);
    if (n == 0) begin
      text_q.push_back(rnd_byte(0, 8'h7F));
    end else if (n == 1) begin
      text_q.push_back(rnd_byte(8'hA1, 8'hDF));
    end else begin
      text_q.push_back($urandom_range(0, 1) ? rnd_byte(8'h81, 8'h9F) : rnd_byte(8'hE0, 8'hFC));
      text_q.push_back($urandom_range(0, 1) ? rnd_byte(8'h40, 8'h7E) : rnd_byte(8'h80, 8'hFC));
    end
  endtask

  task automatic make_text(input bit brief);
    int pick;
    int len;
    int pos;
    text_q.delete();
    pick = $urandom_range(0, 99);
    if (brief) len = $urandom_range(1, 3);
    else if ($urandom_range(0, 9) == 0) len = $urandom_range(17, 96);
    else len = $urandom_range(1, 16);
    if (pick < 12) begin
      case ($urandom_range(0, 4))
        0: text_q = {8'hEF, 8'hBB, 8'hBF};
        1: text_q = {8'hFF, 8'hFE, 8'h00, 8'h00};
        2: text_q = {8'h00, 8'h00, 8'hFE, 8'hFF};
        3: text_q = {8'hFF, 8'hFE};
        default: text_q = {8'hFE, 8'hFF};
      endcase
    end
    while (text_q.size() < len) begin
      if (pick < 45) add_utf8_char();
      else if (pick < 75) add_sjis_char();
      else if (pick < 85) text_q.push_back(rnd_byte(0, 8'h7F));
      else text_q.push_back(rnd_byte(0, 8'hFF));
    end
    // broken sequences: cut short or one byte overwritten
    if (text_q.size() > 1 && $urandom_range(0, 4) == 0) begin
      if ($urandom_range(0, 1)) begin
        void'(text_q.pop_back());
      end else begin
        pos = $urandom_range(0, text_q.size() - 1);
        text_q[pos] = rnd_byte(0, 8'hFF);
      end
    end
  endtask

  task automatic check_verdict(input logic [ted_pkg::OUT_W-1:0] word);
    verdict_t                  want;
    logic [ted_pkg::ENC_W-1:0] got_enc;
    ted_pkg::score_t           got_u8;
    ted_pkg::score_t           got_sj;
    got_enc = word[ted_pkg::ENC_W-1:0];
    got_u8  = word[ted_pkg::ENC_W +: ted_pkg::SCORE_W];
    got_sj  = word[ted_pkg::ENC_W + ted_pkg::SCORE_W +: ted_pkg::SCORE_W];
    if (exp_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected verdict: enc %0d utf8 %0d sjis %0d", got_enc, got_u8, got_sj);
      return;
    end
    want = exp_q.pop_front();
    verdicts++;
    enc_hits[want.enc]++;
    if (got_enc !== want.enc || got_u8 !== want.u8 || got_sj !== want.sj) begin
      mismatches++;
      if (mismatches <= 10)
        $display("verdict %0d: expected enc %0d utf8 %0d sjis %0d, got enc %0d utf8 %0d sjis %0d",
                 verdicts, want.enc, want.u8, want.sj, got_enc, got_u8, got_sj);
    end
  endtask

  always @(negedge clk) begin
    in_took <= in_tvalid && in_tready;
    if (rst_n && out_tvalid === 1'b1 && out_tready) check_verdict(out_tdata);
  end

  // receiver stall patterns, plus one long hold-off on request
  initial begin
    rx_mode_t mode;
    int       stretch;
    int       tick;
    mode = RX_OPEN;
    stretch = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (stretch == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          stretch = $urandom_range(20, 200);
        end
        stretch--;
        tick++;
        case (mode)
          RX_OPEN:   out_tready <= 1'b1;
          RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_tready <= (tick % 4 == 0);
          default:   out_tready <= ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  initial begin
    int rand_start;
    bit pressed;
    foreach (enc_hits[i]) enc_hits[i] = 0;
    clear_state();
    pressed = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].typed) begin
        pin_next = 1'b1;
        pin_v.enc = plan[i].enc;
        pin_v.u8  = plan[i].u8;
        pin_v.sj  = plan[i].sj;
      end
      push_byte(plan[i].b, plan[i].last);
    end

    rand_start = bytes_sent;
    while (bytes_sent - rand_start < RANDOM_BYTES) begin
      if (!pressed && bytes_sent - rand_start > 500) begin
        // receiver holds off while short buffers keep coming
        steady = 1'b1;
        hold_req = 1'b1;
        repeat (40) begin
          make_text(1'b1);
          send_text();
        end
        steady = 1'b0;
        pressed = 1'b1;
      end
      make_text(1'b0);
      send_text();
    end
    in_tvalid <= 1'b0;

    while (exp_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d bytes in %0d buffers sent, %0d verdicts checked, %0d mismatches",
             bytes_sent, buffers_sent, verdicts, mismatches);
    $display("verdicts: unknown %0d ascii %0d utf8-bom %0d utf32le %0d utf32be %0d %s %0d %0d",
             enc_hits[ted_pkg::ENC_UNKNOWN], enc_hits[ted_pkg::ENC_ASCII],
             enc_hits[ted_pkg::ENC_UTF8_BOM], enc_hits[ted_pkg::ENC_UTF32LE],
             enc_hits[ted_pkg::ENC_UTF32BE], "utf16le/be",
             enc_hits[ted_pkg::ENC_UTF16LE], enc_hits[ted_pkg::ENC_UTF16BE]);
    $display("verdicts: utf8 %0d shift-jis %0d",
             enc_hits[ted_pkg::ENC_UTF8], enc_hits[ted_pkg::ENC_SJIS]);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
